@@ hdl/mbtrs_pkg.sv @@
// Package: shared constants, codes and types of the Modbus TCP register server.
`default_nettype none
package mbtrs_pkg;

	localparam int BANK_WORDS_DEF   = 128;
	localparam int SERIAL_WORDS_DEF = 7;
	localparam int FRAME_BYTES_DEF  = 256;
	localparam int QUEUE_DEPTH      = 4;
	localparam int HEAD_BYTES       = 13;
	localparam int RESP_HEAD_BYTES  = 12;
	localparam int MAX_COUNT        = 125;

	localparam logic [1:0] MODE_BYTE   = 2'd0;
	localparam logic [1:0] MODE_UPDATE = 2'd1;
	localparam logic [1:0] MODE_OPEN   = 2'd2;

	localparam logic CFG_PHASE  = 1'b0;
	localparam logic CFG_SERIAL = 1'b1;

	localparam logic [7:0] FC_READ_HOLD   = 8'h03;
	localparam logic [7:0] FC_READ_INPUT  = 8'h04;
	localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
	localparam logic [7:0] FC_WRITE_MULTI = 8'h10;
	localparam logic [7:0] EXC_FLAG       = 8'h80;
	localparam logic [7:0] EXC_FUNCTION   = 8'h01;
	localparam logic [7:0] EXC_VALUE      = 8'h03;

	localparam logic [15:0] ADDR_VER_A  = 16'h0302;
	localparam logic [15:0] ADDR_VER_B  = 16'h0304;
	localparam logic [15:0] VER_WORD    = 16'h0100;
	localparam logic [15:0] ADDR_PHASE  = 16'h1002;
	localparam logic [15:0] ADDR_ID_A   = 16'ha000;
	localparam logic [15:0] ID_A_WORD   = 16'd7;
	localparam logic [15:0] ADDR_ID_B   = 16'ha100;
	localparam logic [15:0] ID_B_WORD   = 16'd2;
	localparam logic [15:0] SERIAL_BASE_RST = 16'd20480;

	typedef enum logic [1:0] {
		CMD_UPDATE,
		CMD_CLOSE,
		CMD_FRAME
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] tid;
		logic [7:0]  unit;
		logic [7:0]  fc;
		logic [15:0] w0;
		logic [15:0] w1;
		logic        short12;
		logic        short13;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_HDR,
		B_READ,
		B_MAP,
		B_HI,
		B_LO
	} back_state_t;

endpackage
`default_nettype wire

@@ hdl/mbtrs_ifs.sv @@
// Interfaces: input, output and configuration channels.
`default_nettype none
interface mbtrs_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  rx_byte;
	logic [15:0] reg_address;
	logic [15:0] reg_value;
	modport source (output valid, mode, rx_byte, reg_address, reg_value, input ready);
	modport sink (input valid, mode, rx_byte, reg_address, reg_value, output ready);
endinterface

interface mbtrs_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] tx_bytes;
	logic [3:0]  tx_count;
	logic        tx_last;
	logic        close_link;
	modport source (output valid, tx_bytes, tx_count, tx_last, close_link, input ready);
	modport sink (input valid, tx_bytes, tx_count, tx_last, close_link, output ready);
endinterface

interface mbtrs_cfg_if;
	logic        valid;
	logic        ready;
	logic        addr;
	logic [15:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

@@ hdl/mbtrs_front.sv @@
// Front end: frame assembly, header check and command issue.
`default_nettype none
module mbtrs_front #(
	parameter int FRAME_BYTES = mbtrs_pkg::FRAME_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	mbtrs_in_if.sink                  in_ch,
	input  wire logic                 hold,
	input  wire mbtrs_pkg::queue_stat_t qstat,
	output logic                      push,
	output mbtrs_pkg::cmd_t           cmd
);
	localparam int FILL_W = $clog2(FRAME_BYTES + 1);

	logic [FILL_W-1:0] fill_q, total_q, fill_n;
	logic              open_q;
	logic [7:0]        head_q [mbtrs_pkg::HEAD_BYTES];
	logic [7:0]        head_n [mbtrs_pkg::HEAD_BYTES];
	logic              acc, is_byte, is_upd, hdr_chk, done, bad;
	logic [15:0]       proto, plen;
	logic [16:0]       sum;

	assign in_ch.ready = !hold && !qstat.full;
	assign acc = in_ch.valid && in_ch.ready;
	assign is_byte = acc && (in_ch.mode == mbtrs_pkg::MODE_BYTE) && open_q;
	assign is_upd = acc && (in_ch.mode == mbtrs_pkg::MODE_UPDATE);

	always_comb begin
		head_n = head_q;
		if (fill_q < FILL_W'(mbtrs_pkg::HEAD_BYTES)) begin
			head_n[fill_q[3:0]] = in_ch.rx_byte;
		end
	end

	assign fill_n = fill_q + FILL_W'(1);
	assign proto = {head_n[2], head_n[3]};
	assign plen = {head_n[4], head_n[5]};
	assign sum = 17'd6 + {1'b0, plen};
	assign bad = (proto != 16'd0) || (plen < 16'd2) || (sum > 17'(FRAME_BYTES));
	assign hdr_chk = (fill_n == FILL_W'(6));
	assign done = (fill_n > FILL_W'(6)) && (fill_n >= total_q);

	assign push = is_upd || (is_byte && (hdr_chk ? bad : done));

	always_comb begin
		cmd.kind = is_upd ? mbtrs_pkg::CMD_UPDATE
			: (hdr_chk ? mbtrs_pkg::CMD_CLOSE : mbtrs_pkg::CMD_FRAME);
		cmd.tid = {head_n[0], head_n[1]};
		cmd.unit = head_n[6];
		cmd.fc = head_n[7];
		cmd.w0 = is_upd ? in_ch.reg_address : {head_n[8], head_n[9]};
		cmd.w1 = is_upd ? in_ch.reg_value : {head_n[10], head_n[11]};
		cmd.short12 = total_q < FILL_W'(12);
		cmd.short13 = total_q < FILL_W'(13);
	end

	always_ff @(posedge clk) begin
		if (is_byte) begin
			head_q <= head_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			total_q <= '0;
			open_q <= 1'b0;
		end else if (acc && in_ch.mode == mbtrs_pkg::MODE_OPEN) begin
			fill_q <= '0;
			total_q <= '0;
			open_q <= 1'b1;
		end else if (is_byte) begin
			if (hdr_chk && bad) begin
				fill_q <= '0;
				total_q <= '0;
				open_q <= 1'b0;
			end else if (hdr_chk) begin
				fill_q <= fill_n;
				total_q <= sum[FILL_W-1:0];
			end else if (done) begin
				fill_q <= '0;
				total_q <= '0;
			end else begin
				fill_q <= fill_n;
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/mbtrs_queue.sv @@
// Command queue between front end and back end.
`default_nettype none
module mbtrs_queue #(
	parameter int DEPTH = mbtrs_pkg::QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire mbtrs_pkg::cmd_t       wdata,
	input  wire logic                  pop,
	output mbtrs_pkg::cmd_t            rdata,
	output mbtrs_pkg::queue_stat_t     stat
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	mbtrs_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;

	assign stat.full = (cnt_q == (PW+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full && !pop)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("queue underflow");
`endif
endmodule
`default_nettype wire

@@ hdl/mbtrs_back.sv @@
// Back end: register map, response builder and output packing.
`default_nettype none
module mbtrs_back #(
	parameter int BANK_WORDS   = mbtrs_pkg::BANK_WORDS_DEF,
	parameter int SERIAL_WORDS = mbtrs_pkg::SERIAL_WORDS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mbtrs_pkg::queue_stat_t qstat,
	input  wire mbtrs_pkg::cmd_t        cmd,
	output logic                        pop,
	output logic                        clr_busy,
	input  wire logic [1:0]             phase,
	input  wire logic [15:0]            serial_base,
	mbtrs_out_if.source                 out_ch
);
	localparam int BIDX_W = $clog2(BANK_WORDS);
	localparam int SIDX_W = (SERIAL_WORDS > 1) ? $clog2(SERIAL_WORDS) : 1;
	localparam int RH = mbtrs_pkg::RESP_HEAD_BYTES;

	mbtrs_pkg::back_state_t state_q, state_n;

	logic [15:0]       bank_mem [BANK_WORDS];
	logic [15:0]       bank_q;
	logic [BIDX_W-1:0] clr_q;
	logic [15:0]       serial_q [SERIAL_WORDS];

	logic [7:0]  hdr_q [RH];
	logic [7:0]  h [RH];
	logic [3:0]  hdr_len_q, hlen;
	logic [3:0]  p_q;
	logic [6:0]  words_q, nwords;
	logic [15:0] addr_q, word_q, mapv;

	logic [63:0] acc_q, acc_new;
	logic [3:0]  accn_q, n1;
	logic        out_v_q, out_last_q, out_close_q;
	logic [63:0] out_data_q;
	logic [3:0]  out_count_q;

	logic        can_push, emit, elast, push_close, load, upd;
	logic [7:0]  eb;
	logic        rd, wr, rd_bad;
	logic [15:0] udiff, mdiff;
	logic        u_in_bank, u_in_ser, m_in_ser;

	assign can_push = !out_v_q || out_ch.ready;
	assign clr_busy = (state_q == mbtrs_pkg::B_CLEAR);

	always_comb begin
		state_n = state_q;
		pop = 1'b0;
		emit = 1'b0;
		eb = 8'd0;
		elast = 1'b0;
		push_close = 1'b0;
		load = 1'b0;
		upd = 1'b0;
		case (state_q)
			mbtrs_pkg::B_CLEAR: begin
				if (clr_q == BIDX_W'(BANK_WORDS - 1)) state_n = mbtrs_pkg::B_IDLE;
			end
			mbtrs_pkg::B_IDLE: begin
				if (!qstat.empty) begin
					case (cmd.kind)
						mbtrs_pkg::CMD_UPDATE: begin
							pop = 1'b1;
							upd = 1'b1;
						end
						mbtrs_pkg::CMD_CLOSE: begin
							if (can_push) begin
								pop = 1'b1;
								push_close = 1'b1;
							end
						end
						mbtrs_pkg::CMD_FRAME: begin
							pop = 1'b1;
							load = 1'b1;
							state_n = mbtrs_pkg::B_HDR;
						end
						default: pop = 1'b1;
					endcase
				end
			end
			mbtrs_pkg::B_HDR: begin
				if (can_push) begin
					emit = 1'b1;
					eb = hdr_q[p_q];
					if (p_q == hdr_len_q - 4'd1) begin
						elast = (words_q == 7'd0);
						state_n = (words_q != 7'd0) ? mbtrs_pkg::B_READ : mbtrs_pkg::B_IDLE;
					end
				end
			end
			mbtrs_pkg::B_READ: state_n = mbtrs_pkg::B_MAP;
			mbtrs_pkg::B_MAP: state_n = mbtrs_pkg::B_HI;
			mbtrs_pkg::B_HI: begin
				if (can_push) begin
					emit = 1'b1;
					eb = word_q[15:8];
					state_n = mbtrs_pkg::B_LO;
				end
			end
			mbtrs_pkg::B_LO: begin
				if (can_push) begin
					emit = 1'b1;
					eb = word_q[7:0];
					elast = (words_q == 7'd1);
					state_n = (words_q == 7'd1) ? mbtrs_pkg::B_IDLE : mbtrs_pkg::B_READ;
				end
			end
			default: state_n = mbtrs_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mbtrs_pkg::B_CLEAR;
		else state_q <= state_n;
	end

	// response header and PDU head
	always_comb begin
		rd = (cmd.fc == mbtrs_pkg::FC_READ_HOLD) || (cmd.fc == mbtrs_pkg::FC_READ_INPUT);
		wr = (cmd.fc == mbtrs_pkg::FC_WRITE_ONE) || (cmd.fc == mbtrs_pkg::FC_WRITE_MULTI);
		rd_bad = cmd.short12 || (cmd.w1 == 16'd0) || (cmd.w1 > 16'(mbtrs_pkg::MAX_COUNT));
		for (int i = 0; i < RH; i++) h[i] = 8'd0;
		h[0] = cmd.tid[15:8];
		h[1] = cmd.tid[7:0];
		h[6] = cmd.unit;
		h[5] = 8'd3;
		h[7] = cmd.fc | mbtrs_pkg::EXC_FLAG;
		h[8] = mbtrs_pkg::EXC_VALUE;
		hlen = 4'd9;
		nwords = 7'd0;
		if (rd) begin
			if (!rd_bad) begin
				h[5] = 8'd3 + {cmd.w1[6:0], 1'b0};
				h[7] = cmd.fc;
				h[8] = {cmd.w1[6:0], 1'b0};
				nwords = cmd.w1[6:0];
			end
		end else if (wr) begin
			if (!((cmd.fc == mbtrs_pkg::FC_WRITE_ONE) ? cmd.short12 : cmd.short13)) begin
				h[5] = 8'd6;
				h[7] = cmd.fc;
				h[8] = cmd.w0[15:8];
				h[9] = cmd.w0[7:0];
				h[10] = cmd.w1[15:8];
				h[11] = cmd.w1[7:0];
				hlen = 4'd12;
			end
		end else begin
			h[8] = mbtrs_pkg::EXC_FUNCTION;
		end
	end

	assign udiff = cmd.w0 - serial_base;
	assign u_in_bank = {1'b0, cmd.w0} < 17'(BANK_WORDS);
	assign u_in_ser = ({1'b0, cmd.w0} >= {1'b0, serial_base})
		&& ({1'b0, cmd.w0} < {1'b0, serial_base} + 17'(SERIAL_WORDS));

	assign mdiff = addr_q - serial_base;
	assign m_in_ser = ({1'b0, addr_q} >= {1'b0, serial_base})
		&& ({1'b0, addr_q} < {1'b0, serial_base} + 17'(SERIAL_WORDS));

	always_comb begin
		if ({1'b0, addr_q} < 17'(BANK_WORDS)) mapv = bank_q;
		else if (addr_q == mbtrs_pkg::ADDR_VER_A || addr_q == mbtrs_pkg::ADDR_VER_B)
			mapv = mbtrs_pkg::VER_WORD;
		else if (addr_q == mbtrs_pkg::ADDR_PHASE) mapv = {14'd0, phase};
		else if (addr_q == mbtrs_pkg::ADDR_ID_A) mapv = mbtrs_pkg::ID_A_WORD;
		else if (addr_q == mbtrs_pkg::ADDR_ID_B) mapv = mbtrs_pkg::ID_B_WORD;
		else if (m_in_ser) mapv = serial_q[mdiff[SIDX_W-1:0]];
		else mapv = 16'd0;
	end

	always_ff @(posedge clk) begin
		if (state_q == mbtrs_pkg::B_CLEAR) bank_mem[clr_q] <= 16'd0;
		else if (upd && u_in_bank) bank_mem[cmd.w0[BIDX_W-1:0]] <= cmd.w1;
		bank_q <= bank_mem[addr_q[BIDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			for (int i = 0; i < SERIAL_WORDS; i++) serial_q[i] <= 16'd0;
		end else begin
			if (state_q == mbtrs_pkg::B_CLEAR) clr_q <= clr_q + BIDX_W'(1);
			if (upd && u_in_ser) serial_q[udiff[SIDX_W-1:0]] <= cmd.w1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hdr_q <= h;
			hdr_len_q <= hlen;
			words_q <= nwords;
			addr_q <= cmd.w0;
			p_q <= 4'd0;
		end else begin
			if (state_q == mbtrs_pkg::B_HDR && emit) p_q <= p_q + 4'd1;
			if (state_q == mbtrs_pkg::B_MAP) word_q <= mapv;
			if (state_q == mbtrs_pkg::B_LO && emit) begin
				words_q <= words_q - 7'd1;
				addr_q <= addr_q + 16'd1;
			end
		end
	end

	// byte lane insert into the packing word
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (accn_q[2:0] == 3'(i)) acc_new[63-8*i -: 8] = eb;
			else if (accn_q[2:0] < 3'(i)) acc_new[63-8*i -: 8] = 8'd0;
			else acc_new[63-8*i -: 8] = acc_q[63-8*i -: 8];
		end
	end
	assign n1 = accn_q + 4'd1;

	always_ff @(posedge clk) begin
		if (emit) begin
			if (n1 == 4'd8 || elast) begin
				out_data_q <= acc_new;
				out_count_q <= n1;
				out_last_q <= elast;
				out_close_q <= 1'b0;
			end else begin
				acc_q <= acc_new;
			end
		end else if (push_close) begin
			out_data_q <= 64'd0;
			out_count_q <= 4'd0;
			out_last_q <= 1'b1;
			out_close_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			accn_q <= 4'd0;
		end else begin
			if (emit) begin
				if (n1 == 4'd8 || elast) begin
					out_v_q <= 1'b1;
					accn_q <= 4'd0;
				end else begin
					accn_q <= n1;
					if (out_ch.ready) out_v_q <= 1'b0;
				end
			end else if (push_close) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.tx_bytes = out_data_q;
	assign out_ch.tx_count = out_count_q;
	assign out_ch.tx_last = out_last_q;
	assign out_ch.close_link = out_close_q;

`ifndef NO_ASSERTIONS
	a_close_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_close_q) |-> (out_count_q == 4'd0 && out_last_q))
		else $error("close transfer malformed");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbtrs_pkg::B_CLEAR) |-> !pop)
		else $error("command taken during bank clear");
	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbtrs_pkg::B_LO && emit && words_q == 7'd1) |=> (out_v_q && out_last_q))
		else $error("final read word did not end the response");
`endif
endmodule
`default_nettype wire

@@ hdl/modbus_tcp_register_server_unit.sv @@
// Top level: Modbus TCP register server for one connection.
// Request bytes are taken one per cycle while the queue has room and the bank is not
// being cleared, and are framed by the front end; each complete frame, header failure or
// bank update becomes a command in a four-entry queue that the back end executes. A
// response leaves as transfers of up to 8 bytes: header bytes go out one per cycle while
// the output is not stalled, and each read word goes through a bank read, a map select
// and a step for each of its two bytes. After reset the register bank is cleared, during
// which no input transfer is taken; configuration writes are taken at any time.
`default_nettype none
module modbus_tcp_register_server_unit #(
	parameter int BANK_WORDS   = mbtrs_pkg::BANK_WORDS_DEF,
	parameter int SERIAL_WORDS = mbtrs_pkg::SERIAL_WORDS_DEF,
	parameter int FRAME_BYTES  = mbtrs_pkg::FRAME_BYTES_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	mbtrs_in_if.sink   in_ch,
	mbtrs_out_if.source out_ch,
	mbtrs_cfg_if.sink  cfg
);
	logic [1:0]  phase_q;
	logic [15:0] serial_base_q;

	mbtrs_pkg::queue_stat_t qstat;
	mbtrs_pkg::cmd_t        push_cmd, head_cmd;
	logic                   push, pop, clr_busy;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			serial_base_q <= mbtrs_pkg::SERIAL_BASE_RST;
		end else if (cfg.valid) begin
			case (cfg.addr)
				mbtrs_pkg::CFG_PHASE: phase_q <= cfg.data[1:0];
				mbtrs_pkg::CFG_SERIAL: serial_base_q <= cfg.data;
				default: ;
			endcase
		end
	end

	mbtrs_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .hold(clr_busy),
		.qstat(qstat), .push(push), .cmd(push_cmd)
	);

	mbtrs_queue #(.DEPTH(mbtrs_pkg::QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(push_cmd),
		.pop(pop), .rdata(head_cmd), .stat(qstat)
	);

	mbtrs_back #(.BANK_WORDS(BANK_WORDS), .SERIAL_WORDS(SERIAL_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n), .qstat(qstat), .cmd(head_cmd), .pop(pop),
		.clr_busy(clr_busy), .phase(phase_q), .serial_base(serial_base_q), .out_ch(out_ch)
	);
endmodule
`default_nettype wire

@@ dv/mbtrs_checker.sv @@
// Checker: watches the channels, predicts responses of the register server and compares them.
`timescale 1ns / 100ps
module mbtrs_checker (
	input  logic clk,
	input  logic arst_n,
	mbtrs_in_if  in_ch,
	mbtrs_out_if out_ch,
	mbtrs_cfg_if cfg,
	output int   errors,
	output int   pending
);
	import mbtrs_pkg::*;

	localparam int BANK   = BANK_WORDS_DEF;
	localparam int SERIAL = SERIAL_WORDS_DEF;
	localparam int FRAME  = FRAME_BYTES_DEF;

	typedef struct {
		logic [63:0] bytes;
		logic [3:0]  cnt;
		logic        last;
		logic        close;
	} tx_item_t;

	tx_item_t    tx_expected[$];
	logic [15:0] bank[BANK];
	logic [15:0] serial[SERIAL];
	logic [7:0]  head[HEAD_BYTES];
	int          fill;
	int          total;
	bit          link_up;
	logic [1:0]  phase;
	logic [15:0] sbase;
	int          err_cnt;

	function automatic logic [15:0] map_word(input int a);
		if (a < BANK) return bank[a];
		if (a == ADDR_VER_A || a == ADDR_VER_B) return VER_WORD;
		if (a == ADDR_PHASE) return {14'd0, phase};
		if (a == ADDR_ID_A) return ID_A_WORD;
		if (a == ADDR_ID_B) return ID_B_WORD;
		if (a >= int'(sbase) && a < int'(sbase) + SERIAL) return serial[a - int'(sbase)];
		return 16'd0;
	endfunction

	function automatic void answer_frame();
		logic [7:0]  rsp[0:7 + 2 + 2 * MAX_COUNT];
		logic [7:0]  fc;
		int          plen, start, cnt, pos, n, k, v;
		logic [15:0] w;
		tx_item_t    it;
		fc = head[7];
		if (fc == FC_READ_HOLD || fc == FC_READ_INPUT) begin
			start = {head[8], head[9]};
			cnt = {head[10], head[11]};
			if (total < 12 || cnt == 0 || cnt > MAX_COUNT) begin
				rsp[7] = fc | EXC_FLAG; rsp[8] = EXC_VALUE; plen = 2;
			end else begin
				rsp[7] = fc;
				rsp[8] = 8'(cnt * 2);
				for (k = 0; k < cnt; k++) begin
					w = map_word((start + k) & 16'hffff);
					rsp[9 + 2 * k] = w[15:8];
					rsp[10 + 2 * k] = w[7:0];
				end
				plen = 2 + cnt * 2;
			end
		end else if (fc == FC_WRITE_ONE || fc == FC_WRITE_MULTI) begin
			if (total < ((fc == FC_WRITE_ONE) ? 12 : 13)) begin
				rsp[7] = fc | EXC_FLAG; rsp[8] = EXC_VALUE; plen = 2;
			end else begin
				rsp[7] = fc;
				for (k = 0; k < 4; k++) rsp[8 + k] = head[8 + k];
				plen = 5;
			end
		end else begin
			rsp[7] = fc | EXC_FLAG; rsp[8] = EXC_FUNCTION; plen = 2;
		end
		v = 1 + plen;
		rsp[0] = head[0];
		rsp[1] = head[1];
		rsp[2] = 8'd0;
		rsp[3] = 8'd0;
		rsp[4] = 8'(v >> 8);
		rsp[5] = 8'(v);
		rsp[6] = head[6];
		pos = 0;
		while (pos < 7 + plen) begin
			n = 7 + plen - pos;
			if (n > 8) n = 8;
			it.bytes = '0;
			for (k = 0; k < 8; k++) it.bytes = {it.bytes[55:0], (k < n) ? rsp[pos + k] : 8'd0};
			pos += n;
			it.cnt = 4'(n);
			it.last = (pos >= 7 + plen);
			it.close = 1'b0;
			tx_expected.push_back(it);
		end
	endfunction

	function automatic void predict_transfer(input logic [1:0] md, input logic [7:0] b,
			input logic [15:0] addr, input logic [15:0] val);
		int       pl;
		tx_item_t it;
		if (md == MODE_UPDATE) begin
			if (addr < BANK) bank[addr] = val;
			if (int'(addr) >= int'(sbase) && int'(addr) < int'(sbase) + SERIAL)
				serial[int'(addr) - int'(sbase)] = val;
			return;
		end
		if (md == MODE_OPEN) begin
			fill = 0; total = 0; link_up = 1;
			return;
		end
		if (md != MODE_BYTE || !link_up) return;
		if (fill < HEAD_BYTES) head[fill] = b;
		fill++;
		if (fill == 6) begin
			pl = {head[4], head[5]};
			if ({head[2], head[3]} != 16'd0 || pl < 2 || 6 + pl > FRAME) begin
				fill = 0; total = 0; link_up = 0;
				it.bytes = '0; it.cnt = '0; it.last = 1'b1; it.close = 1'b1;
				tx_expected.push_back(it);
			end else begin
				total = 6 + pl;
			end
		end else if (fill > 6 && fill >= total) begin
			answer_frame();
			fill = 0; total = 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tx_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < BANK; i++) bank[i] = '0;
			for (int i = 0; i < SERIAL; i++) serial[i] = '0;
			for (int i = 0; i < HEAD_BYTES; i++) head[i] = '0;
			fill = 0; total = 0; link_up = 0;
			phase = '0; sbase = SERIAL_BASE_RST;
			tx_expected.delete();
			err_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.addr == CFG_PHASE) phase = cfg.data[1:0];
				else sbase = cfg.data;
			end
			if (in_ch.valid && in_ch.ready)
				predict_transfer(in_ch.mode, in_ch.rx_byte, in_ch.reg_address, in_ch.reg_value);
			if (out_ch.valid && out_ch.ready) begin
				if (tx_expected.size() == 0) begin
					$error("unexpected transfer tx_bytes=%h", out_ch.tx_bytes);
					err_cnt++;
				end else begin
					want = tx_expected.pop_front();
					if (out_ch.tx_bytes !== want.bytes) begin
						$error("tx_bytes expected %h actual %h", want.bytes, out_ch.tx_bytes);
						err_cnt++;
					end
					if (out_ch.tx_count !== want.cnt) begin
						$error("tx_count expected %0d actual %0d", want.cnt, out_ch.tx_count);
						err_cnt++;
					end
					if (out_ch.tx_last !== want.last) begin
						$error("tx_last expected %0b actual %0b", want.last, out_ch.tx_last);
						err_cnt++;
					end
					if (out_ch.close_link !== want.close) begin
						$error("close_link expected %0b actual %0b", want.close, out_ch.close_link);
						err_cnt++;
					end
				end
			end
			errors <= err_cnt;
			pending <= tx_expected.size();
		end
	end
endmodule

@@ dv/tb_modbus_tcp_register_server_unit.sv @@
// Testbench top: stimulus, output stalls and verdict for the Modbus TCP register server.
`timescale 1ns / 100ps
module tb_modbus_tcp_register_server_unit;
	import mbtrs_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN = 700;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   cycles;
	int   sent;
	bit   calm;
	int   hold_req;
	int   hold_seen;
	int   hold_left;

	mbtrs_in_if  in_if();
	mbtrs_out_if out_if();
	mbtrs_cfg_if cfg_if();

	modbus_tcp_register_server_unit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_if), .out_ch(out_if), .cfg(cfg_if)
	);

	mbtrs_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_if), .out_ch(out_if), .cfg(cfg_if),
		.errors(errors), .pending(pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stalls plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			out_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 400;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= calm || $urandom_range(99) >= 6;
		end
	end

	task automatic send_item(input logic [1:0] md, input logic [7:0] b,
			input logic [15:0] addr, input logic [15:0] val);
		if (!calm && $urandom_range(99) < 6) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.mode <= md;
		in_if.rx_byte <= b;
		in_if.reg_address <= addr;
		in_if.reg_value <= val;
		do @(posedge clk); while (!in_if.ready);
		sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(MODE_BYTE, b, 16'($urandom), 16'($urandom));
	endtask

	task automatic open_link();
		send_item(MODE_OPEN, 8'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic update_reg(input logic [15:0] addr, input logic [15:0] val);
		send_item(MODE_UPDATE, 8'($urandom), addr, val);
	endtask

	task automatic send_frame(input logic [15:0] proto, input logic [7:0] fc,
			input logic [15:0] w0, input logic [15:0] w1, input int plen);
		logic [7:0]  hdr[12];
		logic [15:0] tid, pl;
		int          n;
		tid = 16'($urandom);
		pl = 16'(plen);
		hdr = '{tid[15:8], tid[7:0], proto[15:8], proto[7:0], pl[15:8], pl[7:0],
			8'($urandom), fc, w0[15:8], w0[7:0], w1[15:8], w1[7:0]};
		n = (proto != 0 || plen < 2 || plen > FRAME_BYTES_DEF - 6) ? 6 : 6 + plen;
		for (int k = 0; k < n; k++) send_byte((k < 12) ? hdr[k] : 8'($urandom));
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		in_if.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.addr <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_addr();
		case ($urandom_range(7))
			0: return 16'($urandom_range(127));
			1: return 16'($urandom_range(16'h0300, 16'h0306));
			2: return 16'($urandom_range(16'h1000, 16'h1003));
			3: return $urandom_range(1) ? ADDR_ID_A : ADDR_ID_B;
			4: return 16'(20480 + $urandom_range(9) - 2);
			5: return 16'($urandom_range(16'hfff0, 16'hffff));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_phase(input int goal);
		int          r, cnt;
		logic [7:0]  fc;
		while (sent < goal) begin
			r = $urandom_range(99);
			if (r < 5) begin
				open_link();
			end else if (r < 18) begin
				update_reg($urandom_range(1) ? 16'($urandom_range(127)) : pick_addr(),
					16'($urandom));
			end else if (r < 21) begin
				repeat ($urandom_range(1, 4))
					send_item(2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
				open_link();
			end else if (r < 25) begin
				case ($urandom_range(2))
					0: send_frame(16'($urandom_range(1, 65535)), FC_READ_HOLD, 0, 1, 6);
					1: send_frame(16'd0, FC_READ_HOLD, 0, 1, $urandom_range(1) ? 0 : 1);
					default: send_frame(16'd0, FC_READ_HOLD, 0, 1,
						$urandom_range(FRAME_BYTES_DEF - 5, 65535));
				endcase
				open_link();
			end else begin
				r = $urandom_range(99);
				if (r < 55) fc = $urandom_range(1) ? FC_READ_HOLD : FC_READ_INPUT;
				else if (r < 70) fc = FC_WRITE_ONE;
				else if (r < 85) fc = FC_WRITE_MULTI;
				else fc = 8'($urandom);
				r = $urandom_range(99);
				if (r < 80) cnt = $urandom_range(1, 8);
				else if (r < 85) cnt = 0;
				else if (r < 90) cnt = $urandom_range(126, 65535);
				else if (r < 93) cnt = MAX_COUNT;
				else cnt = $urandom_range(9, 40);
				r = $urandom_range(99);
				send_frame(16'd0, fc, pick_addr(), 16'(cnt),
					(r < 70) ? 6 : (r < 85) ? 7 : (r < 97) ? $urandom_range(2, 12)
					: $urandom_range(13, 60));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
		sent = 0;
		calm = 0;
		hold_req = 0;
		in_if.valid = 1'b0;
		in_if.mode = MODE_BYTE;
		in_if.rx_byte = '0;
		in_if.reg_address = '0;
		in_if.reg_value = '0;
		cfg_if.valid = 1'b0;
		cfg_if.addr = CFG_PHASE;
		cfg_if.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		send_byte(8'h55);
		open_link();
		update_reg(16'd0, 16'hffff);
		update_reg(16'd127, 16'h8001);
		update_reg(16'd20486, 16'h1234);
		update_reg(16'hffff, 16'hbeef);
		send_frame(16'd0, FC_READ_HOLD, 16'd0, 16'd1, 6);
		send_frame(16'd0, FC_READ_INPUT, 16'h007e, 16'd125, 6);
		send_frame(16'd0, FC_READ_INPUT, 16'h4ffe, 16'd10, 6);
		send_frame(16'd0, FC_WRITE_ONE, 16'h1234, 16'hffff, 5);
		send_frame(16'd0, FC_WRITE_MULTI, 16'h0001, 16'd2, 7);
		send_frame(16'hffff, FC_READ_HOLD, 16'd0, 16'd1, 6);
		send_byte(8'h00);
		send_item(2'd3, 8'hff, 16'hffff, 16'hffff);
		open_link();
		send_frame(16'd0, FC_READ_HOLD, 16'd0, 16'd1, 1);
		open_link();
		send_frame(16'd0, FC_READ_HOLD, 16'd0, 16'd1, FRAME_BYTES_DEF - 5);
		open_link();

		write_reg(CFG_PHASE, 16'd3);
		write_reg(CFG_SERIAL, 16'hfffd);
		open_link();
		update_reg(16'hfffe, 16'hcafe);
		send_frame(16'd0, FC_READ_HOLD, ADDR_PHASE, 16'd1, 6);
		send_frame(16'd0, FC_READ_HOLD, 16'hfffa, 16'd10, 6);

		// output held off while requests keep coming
		hold_req++;
		repeat (6) send_frame(16'd0, FC_READ_HOLD, 16'd0, 16'd4, 2);

		random_phase(180);
		write_reg(CFG_SERIAL, 16'd0);
		write_reg(CFG_PHASE, 16'd0);
		open_link();
		calm = 1;
		random_phase(205);
		calm = 0;
		write_reg(CFG_PHASE, 16'd2);
		write_reg(CFG_SERIAL, 16'd100);
		open_link();
		random_phase(215);
		write_reg(CFG_SERIAL, 16'hffff);
		write_reg(CFG_PHASE, 16'd1);
		open_link();
		random_phase(222);

		in_if.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

@@ modbus_tcp_register_server_unit.f @@
hdl/mbtrs_pkg.sv
hdl/mbtrs_ifs.sv
hdl/mbtrs_front.sv
hdl/mbtrs_queue.sv
hdl/mbtrs_back.sv
hdl/modbus_tcp_register_server_unit.sv
dv/mbtrs_checker.sv
dv/tb_modbus_tcp_register_server_unit.sv
